FILE: rtl/ll1p_pkg.sv
// Package for the LL(1) predictive parser core: sizes, command codes and payload types.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
package ll1p_pkg;
  localparam int MAX_TERMINALS    = 8;
  localparam int MAX_NONTERMINALS = 8;
  localparam int MAX_PRODUCTIONS  = 16;
  localparam int MAX_BODY         = 8;
  localparam int STACK_DEPTH      = 64;
  localparam int MAX_EXPANSIONS   = 16;

  localparam int SP_W  = 7;   // holds 0..STACK_DEPTH
  localparam int SA_W  = 6;   // stack address
  localparam int PT_AW = 6;   // parse table address
  localparam int BS_AW = 7;   // body symbol address

  localparam logic [7:0] END_MARK = 8'd36;

  localparam logic [2:0] CMD_LOAD_T   = 3'd0;
  localparam logic [2:0] CMD_LOAD_N   = 3'd1;
  localparam logic [2:0] CMD_TABLE    = 3'd2;
  localparam logic [2:0] CMD_BODY_SYM = 3'd3;
  localparam logic [2:0] CMD_BODY_LEN = 3'd4;
  localparam logic [2:0] CMD_BEGIN    = 3'd5;
  localparam logic [2:0] CMD_TOKEN    = 3'd6;
  localparam logic [2:0] CMD_END      = 3'd7;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_CONSUMED = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_TCNT  = 2'd1;
  localparam logic [1:0] REG_NCNT  = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] row;
    logic [2:0] col;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] expansions;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_symbol;
    logic [3:0] terminal_count;
    logic [3:0] nonterminal_count;
  } cfg_t;
endpackage

FILE: rtl/ll1p_cfg_regs.sv
// APB-style configuration registers of the LL(1) parser core.
// Depends on ll1p_pkg.
`timescale 1ns / 1ps
module ll1p_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ll1p_pkg::cfg_t cfg
);
  import ll1p_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_symbol      <= 8'd65;
      cfg.terminal_count    <= 4'd6;
      cfg.nonterminal_count <= 4'd5;
    end else if (wr_en) begin
      case (reg_index)
        REG_START: cfg.start_symbol      <= pwdata[7:0];
        REG_TCNT:  cfg.terminal_count    <= pwdata[3:0];
        REG_NCNT:  cfg.nonterminal_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_index)
      REG_START: prdata = {24'd0, cfg.start_symbol};
      REG_TCNT:  prdata = {28'd0, cfg.terminal_count};
      REG_NCNT:  prdata = {28'd0, cfg.nonterminal_count};
      default:   prdata = 32'd0;
    endcase
  end
endmodule

FILE: rtl/ll1p_engine.sv
// Sequencer of the LL(1) parser: tables, symbol stack and the expand/match loop.
// Depends on ll1p_pkg.
`timescale 1ns / 1ps
module ll1p_engine (
  input  logic                clk,
  input  logic                rst,
  input  ll1p_pkg::cfg_t      cfg,
  input  logic                start,
  input  ll1p_pkg::in_item_t  item,
  output logic                busy,
  output logic                done,
  output ll1p_pkg::out_item_t result
);
  import ll1p_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TOP    = 4'd1;  // stack top read issued
  localparam logic [3:0] S_LOOK   = 4'd2;  // top known, search symbols
  localparam logic [3:0] S_TERM   = 4'd3;  // scan terminal table
  localparam logic [3:0] S_NONT   = 4'd4;  // scan nonterminal table
  localparam logic [3:0] S_ENTRY  = 4'd5;  // parse table read
  localparam logic [3:0] S_LEN    = 4'd6;  // body length read
  localparam logic [3:0] S_PUSHRD = 4'd7;  // body symbol read
  localparam logic [3:0] S_PUSHWR = 4'd8;  // body symbol push
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_START  = 4'd10; // start symbol push after begin

  // Memories.
  logic [7:0] term_mem [MAX_TERMINALS];
  logic [7:0] nont_mem [MAX_NONTERMINALS];
  logic [4:0] pt_mem   [MAX_NONTERMINALS*MAX_TERMINALS];
  logic [7:0] body_mem [MAX_PRODUCTIONS*MAX_BODY];
  logic [3:0] len_mem  [MAX_PRODUCTIONS];
  logic [7:0] stack_mem[STACK_DEPTH];

  logic [3:0]      state;
  logic [SP_W-1:0] fill;
  logic            rejected;
  logic [7:0]      tok;
  logic            is_end;
  logic [7:0]      top;
  logic [2:0]      idx;
  logic [3:0]      scan_n;
  logic [2:0]      tcol;
  logic [2:0]      nrow;
  logic [3:0]      prod;
  logic [3:0]      len;
  logic [4:0]      exp_cnt;
  logic [7:0]      rd_body;
  logic [7:0]      rd_term;
  logic [7:0]      rd_nont;
  logic [4:0]      rd_pt;
  logic [3:0]      rd_len;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // Table loads happen only from idle.
  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      case (item.cmd)
        CMD_LOAD_T:   if (!item.row[3]) term_mem[item.row[2:0]] <= item.value;
        CMD_LOAD_N:   if (!item.row[3]) nont_mem[item.row[2:0]] <= item.value;
        CMD_TABLE:    if (!item.row[3]) pt_mem[{item.row[2:0], item.col}] <= item.value[4:0];
        CMD_BODY_SYM: body_mem[{item.row, item.col}] <= item.value;
        CMD_BODY_LEN: len_mem[item.row] <= item.value[3:0];
        default: ;
      endcase
    end
  end

  // Registered reads of the small tables.
  always_ff @(posedge clk) begin
    rd_term <= term_mem[idx];
    rd_nont <= nont_mem[idx];
    rd_pt   <= pt_mem[{nrow, tcol}];
    rd_len  <= len_mem[prod];
    rd_body <= body_mem[{prod, len[2:0] - 3'd1}];
  end

  // Stack memory: one write port, one registered read of the top.
  logic            stk_we;
  logic [SA_W-1:0] stk_wa;
  logic [7:0]      stk_wd;
  logic [7:0]      stk_rd;
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_rd <= stack_mem[fill[SA_W-1:0] - 6'd1];
  end

  // Begin writes the end mark, then the start symbol; expansions push body symbols.
  always_comb begin
    stk_we = 1'b0;
    stk_wa = fill[SA_W-1:0];
    stk_wd = rd_body;
    if (state == S_IDLE && start && item.cmd == CMD_BEGIN) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = END_MARK;
    end else if (state == S_START) begin
      stk_we = 1'b1;
      stk_wd = cfg.start_symbol;
    end else if (state == S_PUSHWR) begin
      stk_we = 1'b1;
    end
  end

  function automatic out_item_t mk(input logic [1:0] s, input logic [4:0] e, input logic o);
    out_item_t r;
    r.status = s; r.expansions = e; r.overflow = o;
    return r;
  endfunction

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      rejected <= 1'b0;
      result   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            exp_cnt <= '0;
            case (item.cmd)
              CMD_BEGIN: begin
                fill     <= 7'd1;
                rejected <= 1'b0;
                result   <= mk(ST_DONE, 5'd0, 1'b0);
                state    <= S_START;
              end
              CMD_TOKEN, CMD_END: begin
                tok    <= (item.cmd == CMD_END) ? END_MARK : item.value;
                is_end <= (item.cmd == CMD_END);
                if (rejected) begin
                  result <= mk(ST_REJECT, 5'd0, 1'b0);
                  state  <= S_DONE;
                end else begin
                  state <= S_TOP;
                end
              end
              default: begin
                result <= mk(ST_DONE, 5'd0, 1'b0);
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_START: begin
          fill  <= 7'd2;
          state <= S_DONE;
        end
        S_TOP: begin
          if (fill == '0) begin
            rejected <= 1'b1;
            result   <= mk(ST_REJECT, exp_cnt, 1'b0);
            state    <= S_DONE;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          top <= stk_rd;
          if (stk_rd >= 8'd65 && stk_rd <= 8'd90) begin
            idx    <= 3'd0;
            scan_n <= (cfg.terminal_count > 4'd8) ? 4'd8 : cfg.terminal_count;
            state  <= S_TERM;
            len    <= 4'd15;  // marks first cycle of scan
          end else if (stk_rd != tok) begin
            rejected <= 1'b1;
            result   <= mk(ST_REJECT, exp_cnt, 1'b0);
            state    <= S_DONE;
          end else begin
            fill <= fill - 1'b1;
            if (is_end) begin
              if (fill == 7'd1) result <= mk(ST_ACCEPT, exp_cnt, 1'b0);
              else begin
                rejected <= 1'b1;
                result   <= mk(ST_REJECT, exp_cnt, 1'b0);
              end
            end else begin
              result <= mk(ST_CONSUMED, exp_cnt, 1'b0);
            end
            state <= S_DONE;
          end
        end
        // Terminal scan: one entry at a time; each compare waits for the registered table read.
        S_TERM: begin
          if (len == 4'd15) begin
            len <= 4'd0;
            if (scan_n == 4'd0) begin
              rejected <= 1'b1;
              result   <= mk(ST_REJECT, exp_cnt, 1'b0);
              state    <= S_DONE;
            end
          end else if (rd_term == tok) begin
            tcol   <= idx;
            idx    <= 3'd0;
            scan_n <= (cfg.nonterminal_count > 4'd8) ? 4'd8 : cfg.nonterminal_count;
            len    <= 4'd15;
            state  <= S_NONT;
          end else if ({1'b0, idx} + 4'd1 >= scan_n) begin
            rejected <= 1'b1;
            result   <= mk(ST_REJECT, exp_cnt, 1'b0);
            state    <= S_DONE;
          end else begin
            idx <= idx + 3'd1;
            len <= 4'd15;
          end
        end
        S_NONT: begin
          if (len == 4'd15) begin
            len <= 4'd0;
            if (scan_n == 4'd0) begin
              rejected <= 1'b1;
              result   <= mk(ST_REJECT, exp_cnt, 1'b0);
              state    <= S_DONE;
            end
          end else if (rd_nont == top) begin
            nrow  <= idx;
            state <= S_ENTRY;
            len   <= 4'd15;
          end else if ({1'b0, idx} + 4'd1 >= scan_n) begin
            rejected <= 1'b1;
            result   <= mk(ST_REJECT, exp_cnt, 1'b0);
            state    <= S_DONE;
          end else begin
            idx <= idx + 3'd1;
            len <= 4'd15;
          end
        end
        S_ENTRY: begin
          if (len == 4'd15) begin
            len <= 4'd0;
          end else if (rd_pt == 5'd0 || rd_pt > 5'(MAX_PRODUCTIONS)) begin
            rejected <= 1'b1;
            result   <= mk(ST_REJECT, exp_cnt, 1'b0);
            state    <= S_DONE;
          end else if (exp_cnt >= 5'(MAX_EXPANSIONS)) begin
            rejected <= 1'b1;
            result   <= mk(ST_REJECT, exp_cnt, 1'b1);
            state    <= S_DONE;
          end else begin
            prod  <= rd_pt[3:0] - 4'd1;
            len   <= 4'd15;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          if (len == 4'd15) begin
            len <= 4'd0;
          end else begin
            if ({3'd0, (rd_len > 4'd8) ? 4'd8 : rd_len} + fill - 7'd1 > 7'(STACK_DEPTH)) begin
              rejected <= 1'b1;
              result   <= mk(ST_REJECT, exp_cnt, 1'b1);
              state    <= S_DONE;
            end else begin
              fill    <= fill - 7'd1;
              len     <= (rd_len > 4'd8) ? 4'd8 : rd_len;
              exp_cnt <= exp_cnt + 5'd1;
              state   <= (rd_len == 4'd0) ? S_TOP : S_PUSHRD;
            end
          end
        end
        S_PUSHRD: state <= S_PUSHWR;
        // Push one body symbol, last symbol of the body first.
        S_PUSHWR: begin
          fill  <= fill + 7'd1;
          len   <= len - 4'd1;
          state <= (len == 4'd1) ? S_TOP : S_PUSHRD;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/ll1_table_driven_parser_core.sv
// Top level of the LL(1) predictive parser core.
// Table scans go one entry at a time, and body symbols are pushed one at a time through the
// single stack write port; results leave through the out_valid/out_data output register.
// One transaction is handled at a time; the next is taken the cycle after the result is.
// Synchronous active-high reset empties the stack, clears rejection, restores registers.
`timescale 1ns / 1ps
module ll1_table_driven_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ll1p_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ll1p_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ll1p_pkg::*;

  cfg_t      cfg;
  logic      busy;
  logic      done;
  logic      start;
  out_item_t result;

  ll1p_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign in_stall = busy || out_valid;
  assign start    = in_valid && !in_stall;

  ll1p_engine u_eng (
    .clk, .rst, .cfg, .start, .item(in_data), .busy, .done, .result
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (done) out_data <= result;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("item taken while busy");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid) else $error("result lost");
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.expansions <= 5'd16) else $error("expansion count out of range");
endmodule
